// ===== src/ost_pkg.sv =====
// Shared types, constants and register map of the orientation-selected countdown timer.
// Used by the tick channel interface, the step logic, the top level and the checker.
package ost_pkg;

   localparam int TimeBits    = 32;
   localparam int DataBits    = 32;
   localparam int FaceBits    = 3;
   localparam int NumRegs     = 8;
   localparam int RegIdxBits  = $clog2(NumRegs);
   localparam int CsrAddrBits = RegIdxBits + 2;

   localparam logic [FaceBits-1:0] FaceTop  = 3'd0;
   localparam logic [FaceBits-1:0] FaceLast = 3'd5;

   localparam logic [RegIdxBits-1:0] REG_DUR_FACE_ONE   = 3'd0;
   localparam logic [RegIdxBits-1:0] REG_ALARM_TOTAL    = 3'd5;
   localparam logic [RegIdxBits-1:0] REG_ALARM_HALF     = 3'd6;
   localparam logic [RegIdxBits-1:0] REG_LONGEST_TIMER  = 3'd7;

   typedef logic [DataBits-1:0] cfg_word_type;
   typedef logic [TimeBits-1:0] time_type;

   localparam cfg_word_type RegReset [NumRegs] = '{
      32'd60000, 32'd180000, 32'd300000, 32'd600000,
      32'd900000, 32'd10000, 32'd500, 32'd3600000
   };

   typedef enum logic [1:0] {
      MODE_STANDBY  = 2'd0,
      MODE_COUNTING = 2'd1,
      MODE_BLINKING = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      TUNE_NONE      = 2'd0,
      TUNE_START     = 2'd1,
      TUNE_INTERRUPT = 2'd2
   } tune_type;

   typedef struct packed {
      mode_type            mode;
      logic [FaceBits-1:0] last_face;
      logic                face_known;
      time_type            mode_deadline;
      time_type            toggle_deadline;
      logic                buzzer_level;
   } state_type;

   typedef struct packed {
      mode_type mode;
      logic     buzzer_on;
      tune_type tune_request;
   } result_type;

endpackage

// ===== src/ost_req_if.sv =====
// Tick channel: valid/ready handshake carrying the time and the face that is up.
// Depends on ost_pkg for field widths.
interface ost_req_if;
   logic                         valid;
   logic                         ready;
   logic [ost_pkg::DataBits-1:0] now_ms;
   logic [ost_pkg::FaceBits-1:0] face_up;

   modport source (output valid, now_ms, face_up, input ready);
   modport sink   (input valid, now_ms, face_up, output ready);
endinterface

// ===== src/ost_rsp_if.sv =====
// Result channel: valid/ready handshake carrying mode, buzzer level and tune request.
// Does not depend on ost_pkg; its field widths are written out directly.
interface ost_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic       buzzer_on;
   logic [1:0] tune_request;

   modport source (output valid, mode, buzzer_on, tune_request, input ready);
   modport sink   (input valid, mode, buzzer_on, tune_request, output ready);
endinterface

// ===== src/ost_step.sv =====
// Next-state and result logic for one tick of the countdown timer.
// Purely combinational; depends on ost_pkg.
module ost_step (
   input  ost_pkg::state_type                 cur,
   input  logic [ost_pkg::DataBits-1:0]       now_ms,
   input  logic [ost_pkg::FaceBits-1:0]       face_up,
   input  ost_pkg::cfg_word_type              cfg [ost_pkg::NumRegs],
   output ost_pkg::state_type                 nxt,
   output ost_pkg::result_type                res
);

   logic [ost_pkg::FaceBits-1:0] face;
   logic                         changed;
   ost_pkg::time_type            now;
   ost_pkg::time_type            duration;
   ost_pkg::time_type            start_deadline;
   ost_pkg::time_type            alarm_deadline;
   ost_pkg::time_type            toggle_next;
   logic                         mode_hit;
   logic                         toggle_hit;
   ost_pkg::tune_type            tune;

   // Faces six and seven count as the top face.
   assign face     = (face_up > ost_pkg::FaceLast) ? ost_pkg::FaceTop : face_up;
   assign changed  = (face != cur.last_face);
   assign now      = now_ms[ost_pkg::TimeBits-1:0];
   assign duration = (face == ost_pkg::FaceTop) ? '0 :
                     cfg[ost_pkg::RegIdxBits'(face - 3'd1)];

   assign start_deadline = now + duration;
   assign alarm_deadline = now + cfg[ost_pkg::REG_ALARM_TOTAL];
   assign toggle_next    = now + cfg[ost_pkg::REG_ALARM_HALF];

   // Wrap-aware deadline tests
   assign mode_hit   = ost_pkg::time_type'(now - cur.mode_deadline)
                       <= cfg[ost_pkg::REG_LONGEST_TIMER];
   assign toggle_hit = ost_pkg::time_type'(now - cur.toggle_deadline)
                       <= cfg[ost_pkg::REG_LONGEST_TIMER];

   always_comb begin
      nxt           = cur;
      nxt.last_face = face;
      if (!cur.face_known) begin
         nxt.face_known = 1'b1;
      end else begin
         unique case (cur.mode)
            ost_pkg::MODE_STANDBY: begin
               if (changed && face != ost_pkg::FaceTop) begin
                  nxt.mode          = ost_pkg::MODE_COUNTING;
                  nxt.mode_deadline = start_deadline;
               end
            end
            ost_pkg::MODE_COUNTING: begin
               if (changed) begin
                  if (face == ost_pkg::FaceTop) begin
                     nxt.mode = ost_pkg::MODE_STANDBY;
                  end else begin
                     nxt.mode_deadline = start_deadline;
                  end
               end else if (mode_hit) begin
                  nxt.mode            = ost_pkg::MODE_BLINKING;
                  nxt.mode_deadline   = alarm_deadline;
                  nxt.buzzer_level    = !cur.buzzer_level;
                  nxt.toggle_deadline = toggle_next;
               end
            end
            ost_pkg::MODE_BLINKING: begin
               if (changed) begin
                  nxt.buzzer_level = 1'b0;
                  if (face == ost_pkg::FaceTop) begin
                     nxt.mode = ost_pkg::MODE_STANDBY;
                  end else begin
                     nxt.mode          = ost_pkg::MODE_COUNTING;
                     nxt.mode_deadline = start_deadline;
                  end
               end else begin
                  // toggle first, expiry then wins
                  if (toggle_hit) begin
                     nxt.buzzer_level    = !cur.buzzer_level;
                     nxt.toggle_deadline = toggle_next;
                  end
                  if (mode_hit) begin
                     nxt.buzzer_level = 1'b0;
                     nxt.mode         = ost_pkg::MODE_STANDBY;
                  end
               end
            end
            default: begin
               nxt.mode = cur.mode;
            end
         endcase
      end
   end

   always_comb begin
      tune = ost_pkg::TUNE_NONE;
      if (cur.face_known && changed) begin
         unique case (cur.mode)
            ost_pkg::MODE_STANDBY: begin
               if (face != ost_pkg::FaceTop) tune = ost_pkg::TUNE_START;
            end
            ost_pkg::MODE_COUNTING: begin
               tune = (face == ost_pkg::FaceTop) ? ost_pkg::TUNE_INTERRUPT
                                                 : ost_pkg::TUNE_START;
            end
            ost_pkg::MODE_BLINKING: begin
               if (face != ost_pkg::FaceTop) tune = ost_pkg::TUNE_START;
            end
            default: begin
               tune = ost_pkg::TUNE_NONE;
            end
         endcase
      end
   end

   assign res.mode         = nxt.mode;
   assign res.buzzer_on    = nxt.buzzer_level;
   assign res.tune_request = tune;

endmodule

// ===== src/orientation_selected_countdown_timer.sv =====
// Orientation-selected countdown timer: a tick is registered in the input register when it is
// accepted, and its result is registered in the result register once that register is free;
// throughput one tick per cycle while the result channel does not stall.
// The step logic between the two registers sets the rate: compares, adds, mode update.
// Synchronous active-high reset clears the mode state and the valid flags of both pipeline stages,
// and restores every configuration register to its default.
// Depends on ost_pkg, ost_req_if, ost_rsp_if and ost_step.
module orientation_selected_countdown_timer (
   input  logic                             clock,
   input  logic                             reset,
   ost_req_if.sink                          req,
   ost_rsp_if.source                        rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ost_pkg::CsrAddrBits-1:0]  csr_paddr,
   input  logic [ost_pkg::DataBits-1:0]     csr_pwdata,
   output logic [ost_pkg::DataBits-1:0]     csr_prdata,
   output logic                             csr_pready
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   ost_pkg::cfg_word_type            cfg_ff [ost_pkg::NumRegs];
   logic [ost_pkg::RegIdxBits-1:0]   csr_idx;
   logic                             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[ost_pkg::CsrAddrBits-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = cfg_ff[csr_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ost_pkg::RegReset;
      end else if (csr_wr) begin
         cfg_ff[csr_idx] <= csr_pwdata;
      end
   end

   // ---------------------------------------------------------------
   // Handshake control
   // ---------------------------------------------------------------
   logic                          in_valid_ff;
   logic [ost_pkg::DataBits-1:0]  in_now_ff;
   logic [ost_pkg::FaceBits-1:0]  in_face_ff;
   logic                          out_valid_ff;
   ost_pkg::result_type           out_res_ff;
   ost_pkg::result_type           out_res_in;
   ost_pkg::state_type            state_ff;
   ost_pkg::state_type            state_in;
   logic                          out_free;
   logic                          advance;
   logic                          take;

   // The result register is free when empty or being drained this cycle.
   assign out_free  = !out_valid_ff || rsp.ready;
   // Move the held tick through the step logic into the result register.
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;
   assign take      = req.valid && req.ready;

   // Capture the tick; payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_now_ff  <= req.now_ms;
         in_face_ff <= req.face_up;
      end
   end

   // ---------------------------------------------------------------
   // Step logic: the timer state is committed only when the tick
   // advances, so the next held tick always sees the updated state.
   // ---------------------------------------------------------------
   ost_step u_step (
      .cur     (state_ff),
      .now_ms  (in_now_ff),
      .face_up (in_face_ff),
      .cfg     (cfg_ff),
      .nxt     (state_in),
      .res     (out_res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode:            ost_pkg::MODE_STANDBY,
                       last_face:       ost_pkg::FaceTop,
                       face_known:      1'b0,
                       mode_deadline:   '0,
                       toggle_deadline: '0,
                       buzzer_level:    1'b0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= out_res_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.mode         = out_res_ff.mode;
   assign rsp.buzzer_on    = out_res_ff.buzzer_on;
   assign rsp.tune_request = out_res_ff.tune_request;

endmodule

// ===== src/ost_checker.sv =====
// Port-level checks on the countdown timer result channel, bound to the top level.
// Depends on ost_pkg and orientation_selected_countdown_timer.
module ost_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_mode,
   input logic       rsp_buzzer_on,
   input logic [1:0] rsp_tune_request
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode)
         && $stable(rsp_buzzer_on) && $stable(rsp_tune_request))
      else $error("stalled result changed");

   // A start tune always comes with counting.
   a_start_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tune_request == ost_pkg::TUNE_START
         |-> rsp_mode == ost_pkg::MODE_COUNTING)
      else $error("start tune without counting");

   // An interrupt drops to standby with the buzzer off.
   a_interrupt_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tune_request == ost_pkg::TUNE_INTERRUPT
         |-> rsp_mode == ost_pkg::MODE_STANDBY && !rsp_buzzer_on)
      else $error("interrupt tune outside standby");

   // Buzzer only sounds while blinking.
   a_buzz_blink: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode != ost_pkg::MODE_BLINKING |-> !rsp_buzzer_on)
      else $error("buzzer on outside blinking");

   // Reset empties the result channel.
   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind orientation_selected_countdown_timer ost_checker u_ost_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_mode         (rsp.mode),
   .rsp_buzzer_on    (rsp.buzzer_on),
   .rsp_tune_request (rsp.tune_request)
);
